// ===== rtl/dhkt_pkg.sv =====
`timescale 1ns / 1ps
package dhkt_pkg;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;

	localparam logic [7:0] BASE_CHAR = 8'd65;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic       operation;
		logic [7:0] key_char;
		logic       last_char;
	} in_word_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] slot;
		logic [5:0] probe_count;
	} out_word_t;

endpackage

// ===== rtl/double_hash_key_table.sv =====
`timescale 1ns / 1ps
// Double-hashing key table. Keys arrive one character per start pulse; a
// non-final character is taken with busy staying low. On the final character
// the block goes busy and probes the table with one shared slot stepper and
// one byte comparator. Each occupied slot that is passed goes through read,
// check and step, and the slot where the probe stops through read and check.
// A lookup whose stored length matches adds a read and a compare for every
// character compared. An insert then copies the key one character at a time.
// A key that is too long answers at once, without going busy. The result
// appears on result/done for exactly one cycle and cannot be stalled. After
// reset the occupancy memory is cleared, one slot per cycle, with busy high.
module double_hash_key_table #(
	parameter int TABLE_SIZE = 59,
	parameter int KEY_CHARS  = 19
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dhkt_pkg::in_word_t  cmd,
	output logic                busy,
	output logic                done,
	output dhkt_pkg::out_word_t result
);

	localparam int SW = $clog2(TABLE_SIZE);
	localparam int KW = $clog2(KEY_CHARS + 1);
	localparam int CW = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
	localparam int NW = $clog2(TABLE_SIZE + 1);
	localparam int DEPTH = TABLE_SIZE * KEY_CHARS;
	localparam int AW = $clog2(DEPTH);
	localparam int SSW = SW + 1;
	localparam logic [SW:0]   TSZ  = (SW + 1)'(TABLE_SIZE);
	localparam logic [SW-1:0] TSM1 = SW'(TABLE_SIZE - 1);
	localparam logic [AW-1:0] KCA  = AW'(KEY_CHARS);

	// (c - BASE_CHAR) mod m for every byte c, built by counting
	function automatic logic [256*SW-1:0] char_fold(int m);
		logic [256*SW-1:0] t;
		int r;
		t = '0;
		r = 0;
		for (int i = 0; i < int'(dhkt_pkg::BASE_CHAR); i++) begin
			r = (r == 0) ? m - 1 : r - 1;
		end
		for (int c = 0; c < 256; c++) begin
			t[c*SW +: SW] = SW'(r);
			r = (r == m - 1) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam logic [256*SW-1:0] HOME_TAB = char_fold(TABLE_SIZE);
	localparam logic [256*SW-1:0] STEP_TAB = char_fold(TABLE_SIZE - 1);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_RD    = 8'b0000_0100,
		S_CHK   = 8'b0000_1000,
		S_CMPRD = 8'b0001_0000,
		S_CMP   = 8'b0010_0000,
		S_STEP  = 8'b0100_0000,
		S_WRITE = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [SW-1:0] home_q, step_q, idx_q, clr_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] len_q;
	logic too_long_q, op_q;
	logic [CW-1:0] ci_q;
	logic [AW-1:0] base_q;
	logic [7:0] kbuf_q [KEY_CHARS];
	logic done_q;
	dhkt_pkg::out_word_t res_q;

	// occupancy and length per slot, cleared by sweep
	logic meta_we;
	logic [SW-1:0] meta_waddr;
	logic [KW:0] meta_wdata, meta_rdata;
	dhkt_ram #(.Width(KW + 1), .Depth(TABLE_SIZE)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
		.raddr(idx_q), .rdata(meta_rdata)
	);

	// stored key characters
	logic chr_we;
	logic [7:0] chr_rdata;
	dhkt_ram #(.Width(8), .Depth(DEPTH)) u_chars (
		.clk(clk), .we(chr_we), .waddr(base_q + AW'(ci_q)), .wdata(kbuf_q[ci_q]),
		.raddr(base_q + AW'(ci_q)), .rdata(chr_rdata)
	);

	// running hashes on the incoming character
	logic [SW-1:0] hc, sc;
	logic [SW:0] hsum, ssum;
	logic [SW-1:0] home_nx, step_nx;
	logic [SSW:0] nidx;
	logic [SW-1:0] idx_nx;
	always_comb begin
		// fold the character by table lookup, then one compare per hash
		hc = HOME_TAB[cmd.key_char*SW +: SW];
		sc = STEP_TAB[cmd.key_char*SW +: SW];
		hsum = {1'b0, home_q} + {1'b0, hc};
		ssum = {1'b0, step_q} + {1'b0, sc};
		home_nx = (hsum >= TSZ) ? SW'(hsum - TSZ) : SW'(hsum);
		step_nx = ((ssum >= {1'b0, TSM1}) ? SW'(ssum - {1'b0, TSM1}) : SW'(ssum))
			+ 1'b1;
		nidx = {2'b0, idx_q} + {2'b0, step_q};
		idx_nx = (nidx >= {1'b0, TSZ}) ? SW'(nidx - {1'b0, TSZ}) : SW'(nidx);
	end

	logic used_r;
	logic [KW-1:0] slen_r;
	assign used_r = meta_rdata[KW];
	assign slen_r = meta_rdata[KW-1:0];

	always_comb begin
		meta_we = 1'b0;
		meta_waddr = idx_q;
		meta_wdata = {1'b1, len_q};
		if (state_q == S_CLEAR) begin
			meta_we = 1'b1;
			meta_waddr = clr_q;
			meta_wdata = '0;
		end else if (state_q == S_CHK && !used_r && op_q == dhkt_pkg::OP_INSERT) begin
			meta_we = 1'b1;
		end
		chr_we = (state_q == S_WRITE);
	end

	// buffer characters
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start && len_q < KW'(KEY_CHARS)) begin
			kbuf_q[CW'(len_q)] <= cmd.key_char;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			home_q <= '0;
			step_q <= '0;
			idx_q <= '0;
			n_q <= '0;
			len_q <= '0;
			too_long_q <= 1'b0;
			op_q <= 1'b0;
			ci_q <= '0;
			base_q <= '0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == TSM1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						if (len_q < KW'(KEY_CHARS)) len_q <= len_q + 1'b1;
						else too_long_q <= 1'b1;
						if (!cmd.last_char) begin
							home_q <= home_nx;
							step_q <= step_nx;
						end else if (too_long_q || len_q >= KW'(KEY_CHARS)) begin
							res_q <= '{dhkt_pkg::ST_TOO_LONG, 6'd0, 6'd0};
							done_q <= 1'b1;
							home_q <= '0; step_q <= '0; len_q <= '0; too_long_q <= 1'b0;
						end else begin
							op_q <= cmd.operation;
							idx_q <= home_nx;
							step_q <= step_nx;
							home_q <= '0;
							n_q <= '0;
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					base_q <= AW'(idx_q) * KCA;
					ci_q <= '0;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (!used_r) begin
						if (op_q == dhkt_pkg::OP_INSERT) begin
							res_q <= '{dhkt_pkg::ST_INSERTED, 6'(idx_q), 6'(n_q)};
							state_q <= S_WRITE;
						end else begin
							res_q <= '{dhkt_pkg::ST_NOT_FOUND, 6'(idx_q), 6'(n_q)};
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (op_q == dhkt_pkg::OP_LOOKUP && slen_r == len_q) begin
						state_q <= S_CMPRD;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_CMPRD: state_q <= S_CMP;
				S_CMP: begin
					if (chr_rdata != kbuf_q[ci_q]) begin
						state_q <= S_STEP;
					end else if (KW'(ci_q) == len_q - 1'b1) begin
						res_q <= '{dhkt_pkg::ST_FOUND, 6'(idx_q), 6'(n_q)};
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ci_q <= ci_q + 1'b1;
						state_q <= S_CMPRD;
					end
				end
				S_STEP: begin
					if (n_q + 1'b1 >= NW'(TABLE_SIZE)) begin
						res_q <= '{(op_q == dhkt_pkg::OP_INSERT) ? dhkt_pkg::ST_FULL
							: dhkt_pkg::ST_NOT_FOUND, 6'd0, 6'(TABLE_SIZE)};
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						n_q <= n_q + 1'b1;
						idx_q <= idx_nx;
						state_q <= S_RD;
					end
				end
				S_WRITE: begin
					if (KW'(ci_q) == len_q - 1'b1) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ci_q <= ci_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q != S_IDLE && state_q != S_CLEAR && done_q == 1'b0) begin
				// per-key state returns to zero once the key is finished
				if ((state_q == S_CHK && !used_r && op_q == dhkt_pkg::OP_LOOKUP)
					|| (state_q == S_WRITE && KW'(ci_q) == len_q - 1'b1)
					|| (state_q == S_CMP && chr_rdata == kbuf_q[ci_q]
						&& KW'(ci_q) == len_q - 1'b1)
					|| (state_q == S_STEP && n_q + 1'b1 >= NW'(TABLE_SIZE))) begin
					len_q <= '0;
					step_q <= '0;
				end
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign result = res_q;

`ifndef SYNTHESIS
	// a result only follows work or a start
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without a word");
	// too-long results carry no slot
	a_long: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == dhkt_pkg::ST_TOO_LONG |-> result.slot == 6'd0)
		else $error("too-long result with slot");
	// probe index stays inside the table
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		busy && state_q != S_CLEAR |-> {1'b0, idx_q} < TSZ)
		else $error("probe index out of range");
`endif

endmodule

// ===== rtl/dhkt_ram.sv =====
`timescale 1ns / 1ps
module dhkt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// write one word, read one word registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam int TABLE_SIZE = 59;
	localparam int KEY_CHARS  = 19;
	localparam int WATCHDOG   = 20000;
	localparam logic [2:0] WANT_ANY = 3'd7;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	dhkt_pkg::in_word_t  cmd = '0;
	logic                busy;
	logic                done;
	dhkt_pkg::out_word_t result;

	double_hash_key_table #(.TABLE_SIZE(TABLE_SIZE), .KEY_CHARS(KEY_CHARS)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .result(result)
	);

	always #6 clk = ~clk;

	// Shadow of the table
	logic [7:0] key_buf [KEY_CHARS];
	int         key_len;
	int         home_sum;
	int         step_sum;
	bit         overflow;
	bit         used [TABLE_SIZE];
	logic [7:0] kept_chars [TABLE_SIZE][KEY_CHARS];
	int         kept_len [TABLE_SIZE];

	dhkt_pkg::out_word_t pending_results [$];
	int         errors = 0;
	int         words_sent = 0;
	int         results_seen = 0;
	int         idle_cycles = 0;
	int         send_gap_pct = 16;
	int         n_inserted = 0, n_found = 0, n_missed = 0, n_full = 0, n_long = 0;

	// Keep the modulo non-negative
	function automatic int pos_mod(int v, int m);
		int r;
		r = v % m;
		if (r < 0) r += m;
		return r;
	endfunction

	function automatic bit slot_holds_key(int s);
		if (kept_len[s] != key_len) return 0;
		for (int i = 0; i < key_len; i++)
			if (kept_chars[s][i] != key_buf[i]) return 0;
		return 1;
	endfunction

	// Advance the hashes and, on the final character, probe the table
	function automatic void hash_and_probe(dhkt_pkg::in_word_t w);
		dhkt_pkg::out_word_t r;
		int idx, n;
		home_sum = pos_mod(home_sum + int'(w.key_char) - int'(dhkt_pkg::BASE_CHAR),
			TABLE_SIZE);
		step_sum = 1 + pos_mod(step_sum + int'(w.key_char) - int'(dhkt_pkg::BASE_CHAR),
			TABLE_SIZE - 1);
		if (key_len < KEY_CHARS) begin
			key_buf[key_len] = w.key_char;
			key_len++;
		end else
			overflow = 1;
		if (!w.last_char) return;
		r = '0;
		idx = home_sum;
		n = 0;
		if (overflow) begin
			r.status = dhkt_pkg::ST_TOO_LONG;
		end else if (w.operation == dhkt_pkg::OP_INSERT) begin
			while (n < TABLE_SIZE && used[idx]) begin
				n++;
				idx = (idx + step_sum) % TABLE_SIZE;
			end
			if (n >= TABLE_SIZE) begin
				r.status = dhkt_pkg::ST_FULL;
				r.probe_count = 6'(n);
			end else begin
				used[idx] = 1;
				kept_len[idx] = key_len;
				for (int i = 0; i < key_len; i++) kept_chars[idx][i] = key_buf[i];
				r.status = dhkt_pkg::ST_INSERTED;
				r.slot = 6'(idx);
				r.probe_count = 6'(n);
			end
		end else begin
			r.status = dhkt_pkg::ST_NOT_FOUND;
			r.probe_count = 6'(TABLE_SIZE);
			while (n < TABLE_SIZE) begin
				if (!used[idx]) begin
					r.slot = 6'(idx);
					r.probe_count = 6'(n);
					break;
				end
				if (slot_holds_key(idx)) begin
					r.status = dhkt_pkg::ST_FOUND;
					r.slot = 6'(idx);
					r.probe_count = 6'(n);
					break;
				end
				n++;
				idx = (idx + step_sum) % TABLE_SIZE;
			end
		end
		key_len = 0;
		home_sum = 0;
		step_sum = 0;
		overflow = 0;
		pending_results.push_back(r);
	endfunction

	// Check each result word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected word %p", $time, result);
			end else begin
				dhkt_pkg::out_word_t e;
				e = pending_results.pop_front();
				case (e.status)
					dhkt_pkg::ST_INSERTED:  n_inserted++;
					dhkt_pkg::ST_FOUND:     n_found++;
					dhkt_pkg::ST_NOT_FOUND: n_missed++;
					dhkt_pkg::ST_FULL:      n_full++;
					default:                n_long++;
				endcase
				if (result.status !== e.status || result.slot !== e.slot
						|| result.probe_count !== e.probe_count) begin
					errors++;
					$display("%0t: expected status %0d slot %0d probes %0d, got %0d %0d %0d",
						$time, e.status, e.slot, e.probe_count,
						result.status, result.slot, result.probe_count);
				end
			end
		end
	end

	// Watchdog: count cycles with nothing accepted
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Send one word, holding start until it is taken
	task automatic send_word(logic op, logic [7:0] ch, logic last);
		bit was_free;
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= '{operation: op, key_char: ch, last_char: last};
		was_free = 1'b0;
		while (!was_free) begin
			// busy is settled mid-cycle and holds through the next edge
			@(negedge clk);
			was_free = !busy;
			@(posedge clk);
		end
		hash_and_probe('{operation: op, key_char: ch, last_char: last});
		words_sent++;
	endtask

	task automatic send_key(logic op, logic [7:0] chars [$]);
		for (int i = 0; i < chars.size(); i++)
			send_word(i == chars.size() - 1 ? op : logic'($urandom_range(1)),
				chars[i], i == chars.size() - 1);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Directed rows; want_status of WANT_ANY means predictor only
	typedef struct {
		logic       op;
		logic [7:0] ch;
		logic       last;
		logic [2:0] want_status;
	} row_t;

	row_t directed [] = '{
		'{dhkt_pkg::OP_LOOKUP, 8'h41, 1'b1, dhkt_pkg::ST_NOT_FOUND},
		'{dhkt_pkg::OP_INSERT, 8'h41, 1'b1, dhkt_pkg::ST_INSERTED},
		'{dhkt_pkg::OP_LOOKUP, 8'h41, 1'b1, dhkt_pkg::ST_FOUND},
		'{dhkt_pkg::OP_INSERT, 8'h41, 1'b1, dhkt_pkg::ST_INSERTED},
		'{dhkt_pkg::OP_INSERT, 8'h00, 1'b0, WANT_ANY},
		'{dhkt_pkg::OP_INSERT, 8'hFF, 1'b1, dhkt_pkg::ST_INSERTED},
		'{dhkt_pkg::OP_LOOKUP, 8'h00, 1'b0, WANT_ANY},
		'{dhkt_pkg::OP_LOOKUP, 8'hFF, 1'b1, dhkt_pkg::ST_FOUND},
		'{dhkt_pkg::OP_LOOKUP, 8'hFF, 1'b0, WANT_ANY},
		'{dhkt_pkg::OP_LOOKUP, 8'h00, 1'b1, WANT_ANY},
		'{dhkt_pkg::OP_INSERT, 8'h7B, 1'b1, WANT_ANY},
		'{dhkt_pkg::OP_LOOKUP, 8'hAA, 1'b1, WANT_ANY},
		'{dhkt_pkg::OP_INSERT, 8'h55, 1'b1, WANT_ANY}
	};

	initial begin
		logic [7:0] k [$];
		dhkt_pkg::out_word_t tail;
		int         len;
		for (int s = 0; s < TABLE_SIZE; s++) begin
			used[s] = 0;
			kept_len[s] = 0;
		end
		key_len = 0; home_sum = 0; step_sum = 0; overflow = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part
		foreach (directed[i]) begin
			send_word(directed[i].op, directed[i].ch, directed[i].last);
			if (directed[i].last && directed[i].want_status != WANT_ANY) begin
				tail = pending_results[$];
				if (tail.status != directed[i].want_status) begin
					errors++;
					$display("%0t: row %0d expected status %0d, got %0d",
						$time, i, directed[i].want_status, tail.status);
				end
			end
		end
		// Longest legal key, then one too long
		k.delete();
		repeat (KEY_CHARS) k.push_back(8'($urandom));
		send_key(dhkt_pkg::OP_INSERT, k);
		send_key(dhkt_pkg::OP_LOOKUP, k);
		k.push_back(8'h5A);
		send_key(dhkt_pkg::OP_INSERT, k);
		wait_drained();

		// Random part over three idling phases
		for (int ph = 0; ph < 3; ph++) begin
			send_gap_pct = (ph == 0) ? 16 : (ph == 1) ? 67 : 0;
			while (words_sent < 40 + (ph + 1) * 200) begin
				k.delete();
				len = ($urandom_range(19) == 0) ? $urandom_range(KEY_CHARS + 3) + 1
					: $urandom_range(4) + 1;
				for (int i = 0; i < len; i++)
					k.push_back($urandom_range(3) == 0 ? 8'($urandom)
						: 8'($urandom_range(68, 65)));
				send_key(logic'($urandom_range(1)), k);
			end
			wait_drained();
		end

		// Fill the table to the brim, then overflow it and search a full table
		for (int i = 0; i < TABLE_SIZE + 3; i++) begin
			k.delete();
			k.push_back(8'($urandom));
			send_key(dhkt_pkg::OP_INSERT, k);
		end
		k.delete();
		k.push_back(8'h42);
		k.push_back(8'h43);
		send_key(dhkt_pkg::OP_LOOKUP, k);
		send_key(dhkt_pkg::OP_LOOKUP, '{8'h41});

		wait_drained();
		repeat (200) @(posedge clk);
		$display("Sent %0d words: %0d inserted, %0d found, %0d not found,", words_sent,
			n_inserted, n_found, n_missed);
		$display("%0d table-full and %0d too-long results, %0d results checked.",
			n_full, n_long, results_seen);
		if (errors == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
